@@ design/bgd_pkg.sv @@
package bgd_pkg;

  // Event codes on the result word
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESS    = 3'd1,
    EV_CONFIG   = 3'd2,
    EV_SHUTDOWN = 3'd3,
    EV_SHORT    = 3'd4
  } gesture_ev_t;

  // Configuration register indexes
  localparam logic [2:0] REG_SHUTDOWN_HOLD = 3'd0;
  localparam logic [2:0] REG_CHORD_HOLD    = 3'd1;
  localparam logic [2:0] REG_SHORT_PRESS   = 3'd2;
  localparam logic [2:0] REG_RELEASE_SETTLE = 3'd3;
  localparam logic [2:0] REG_CHORD_STEP    = 3'd4;

  // Register reset values
  localparam logic [15:0] SHUTDOWN_HOLD_RST  = 16'd3000;
  localparam logic [15:0] CHORD_HOLD_RST     = 16'd2000;
  localparam logic [15:0] SHORT_PRESS_RST    = 16'd1000;
  localparam logic [7:0]  RELEASE_SETTLE_RST = 8'd50;
  localparam logic [9:0]  CHORD_STEP_RST     = 10'd100;

  localparam logic [15:0] CHORD_MAX = 16'hFFFF;

endpackage

@@ design/button_gesture_detector.sv @@
// Button gesture detector.
// Input stream (s_axis_*): one word per millisecond tick carrying the two
// button levels; an accepted word advances the ms clock unless halted.
// Output stream (m_axis_*): exactly one event word per input word, in order:
// none, back press started, enter config, shutdown or short press.
// Configuration: cfg_we/cfg_index/cfg_data write the five timing registers;
// write only while no event is pending on the output.
// Latency: the event for a tick is on m_axis in the cycle after the input
// word is accepted. Throughput: one word per cycle unless the output stalls;
// the gesture state is updated in the accept cycle by one pass of compare
// and add logic, so back-to-back ticks need no gap.
// Stall: a single output register holds the pending event; while it is full
// and m_axis_tready is low, s_axis_tready drops and input words wait.
// Reset (rst, synchronous): timing registers return to 3000/2000/1000/50/100
// ms, the clock and all stamps clear, the next tick is treated as the first.
// After a shutdown event the block answers none to every tick until reset.
module button_gesture_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] back_pressed, [1] buzzer_pressed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] event_res
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bgd_pkg::*;

  // Timing registers
  logic [15:0] shutdown_hold_ms;
  logic [15:0] chord_hold_ms;
  logic [15:0] short_press_ms;
  logic [7:0]  release_settle_ms;
  logic [9:0]  chord_step_ms;

  // Gesture state
  logic [31:0] now_ms;
  logic [31:0] press_start_ms, press_start_ms_next;
  logic [15:0] chord_ms, chord_ms_next;
  logic [31:0] chord_last_ms, chord_last_ms_next;
  logic [31:0] settle_last_ms, settle_last_ms_next;
  logic        back_was_pressed, back_was_pressed_next;
  logic        held_since_boot, held_since_boot_next;
  logic        first_item;
  logic        halted, halted_next;

  // Output register
  logic        out_valid;
  gesture_ev_t out_ev;
  gesture_ev_t ev_next;

  logic        accept;
  logic        back, buzz;
  logic        held_eff;
  logic [31:0] chord_dt, settle_dt, press_dt, short_dt;
  logic [16:0] chord_sum;
  logic [15:0] chord_step_val;

  assign back = s_axis_tdata[0];
  assign buzz = s_axis_tdata[1];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_ev};

  // Write timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_hold_ms  <= SHUTDOWN_HOLD_RST;
      chord_hold_ms     <= CHORD_HOLD_RST;
      short_press_ms    <= SHORT_PRESS_RST;
      release_settle_ms <= RELEASE_SETTLE_RST;
      chord_step_ms     <= CHORD_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHUTDOWN_HOLD:  shutdown_hold_ms  <= cfg_data;
        REG_CHORD_HOLD:     chord_hold_ms     <= cfg_data;
        REG_SHORT_PRESS:    short_press_ms    <= cfg_data;
        REG_RELEASE_SETTLE: release_settle_ms <= cfg_data[7:0];
        REG_CHORD_STEP:     chord_step_ms     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Tick evaluation
  always_comb begin
    press_start_ms_next   = press_start_ms;
    chord_ms_next         = chord_ms;
    chord_last_ms_next    = chord_last_ms;
    settle_last_ms_next   = settle_last_ms;
    back_was_pressed_next = back_was_pressed;
    held_eff              = first_item ? back : held_since_boot;
    held_since_boot_next  = held_eff;
    halted_next           = halted;
    ev_next               = EV_NONE;

    chord_step_val = {6'd0, chord_step_ms};
    chord_dt       = now_ms - chord_last_ms;
    settle_dt      = now_ms - settle_last_ms;
    short_dt       = now_ms - press_start_ms;
    chord_sum      = {1'b0, chord_ms} + {1'b0, chord_step_val};

    if (back) begin
      if (!back_was_pressed) begin
        press_start_ms_next = now_ms;
        ev_next             = EV_PRESS;
      end
      back_was_pressed_next = 1'b1;
      settle_last_ms_next   = now_ms;
      if (buzz) begin
        // step the chord counter once per step period, saturating
        if (chord_dt >= {22'd0, chord_step_ms}) begin
          chord_ms_next      = chord_sum[16] ? CHORD_MAX : chord_sum[15:0];
          chord_last_ms_next = now_ms;
        end
        if (chord_ms_next > chord_hold_ms) begin
          ev_next = EV_CONFIG;
        end
        press_start_ms_next = now_ms;
      end else begin
        chord_ms_next = 16'd0;
      end
    end else if (settle_dt >= {24'd0, release_settle_ms}) begin
      // settled release
      settle_last_ms_next = now_ms;
      if (!held_eff && back_was_pressed && short_dt < {16'd0, short_press_ms}) begin
        ev_next = EV_SHORT;
      end
      chord_ms_next         = 16'd0;
      back_was_pressed_next = 1'b0;
      held_since_boot_next  = 1'b0;
    end

    // back held alone too long: shut down
    press_dt = now_ms - press_start_ms_next;
    if (back && press_dt > {16'd0, shutdown_hold_ms}) begin
      ev_next     = EV_SHUTDOWN;
      halted_next = 1'b1;
    end

    // halted: answer none, hold all state
    if (halted) begin
      press_start_ms_next   = press_start_ms;
      chord_ms_next         = chord_ms;
      chord_last_ms_next    = chord_last_ms;
      settle_last_ms_next   = settle_last_ms;
      back_was_pressed_next = back_was_pressed;
      held_since_boot_next  = held_since_boot;
      halted_next           = 1'b1;
      ev_next               = EV_NONE;
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms           <= 32'd0;
      press_start_ms   <= 32'd0;
      chord_ms         <= 16'd0;
      chord_last_ms    <= 32'd0;
      settle_last_ms   <= 32'd0;
      back_was_pressed <= 1'b0;
      held_since_boot  <= 1'b0;
      first_item       <= 1'b1;
      halted           <= 1'b0;
    end else if (accept) begin
      if (!halted) begin
        now_ms     <= now_ms + 32'd1;
        first_item <= 1'b0;
      end
      press_start_ms   <= press_start_ms_next;
      chord_ms         <= chord_ms_next;
      chord_last_ms    <= chord_last_ms_next;
      settle_last_ms   <= settle_last_ms_next;
      back_was_pressed <= back_was_pressed_next;
      held_since_boot  <= held_since_boot_next;
      halted           <= halted_next;
    end
  end

  // Hold the event word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ev <= ev_next;
    end
  end

endmodule
